// ===== rtl/cmws_pkg.sv =====
// Shared types and constants for the circular minimum window sum block.
// No dependencies; imported by cmws_div and circular_min_window_sum.
package cmws_pkg;

   // Field widths of the request, response and register
   localparam int VALUE_W    = 32;
   localparam int TARGET_W   = 62;
   localparam int START_W    = 11;
   localparam int LEN_W      = 63;
   localparam int RSP_DATA_W = 80;

   // Divider step counter width
   localparam int DIV_CNT_W  = $clog2(TARGET_W);

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_DIV,
      S_MUL,
      S_RD_R,
      S_ADD,
      S_CHK,
      S_SUB,
      S_FIN
   } state_type;

endpackage

// ===== rtl/circular_min_window_sum.sv =====
// Top level: element store, load path, solve sequencer and response register.
// Depends on cmws_pkg and the cmws_div divider.
//
//  channel  direction  signals                          contents (low bit first)
//  req      in         req_tvalid/tready/tdata/tlast    tdata: value[31:0]; tlast: last
//  rsp      out        rsp_tvalid/tready/tdata          tdata: start_index[10:0],
//                                                        run_length[73:11], zero pad
//  csr      in         csr_wr_en/csr_wr_data            target_sum[61:0]
//
// Element requests are accepted back to back while idle. A request with tlast
// starts the solve, during which req_tready is low: a check of the total, the
// restoring divide, a shift-add multiply, then the window walk over 2N positions
// (read, add and check per right step; subtract and check per left step) and the
// response load. A zero total goes straight to the load; a zero remainder skips
// the walk. The single store read port sets the walk pace.
// Synchronous active-high reset clears counts, total, target (to 1) and rsp_tvalid.
// A pending response holds while the next sequence loads; a new result waits for it.
module circular_min_window_sum #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cmws_pkg::VALUE_W-1:0]    req_tdata,   // value
   input  logic                            req_tlast,   // last
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cmws_pkg::RSP_DATA_W-1:0] rsp_tdata,   // start_index, run_length, pad
   input  logic                            csr_wr_en,
   input  logic [cmws_pkg::TARGET_W-1:0]   csr_wr_data  // target_sum
);
   import cmws_pkg::*;

   localparam int CW  = $clog2(MAX_ELEMENTS + 1);
   localparam int AW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int PW  = CW + 1;
   localparam int TW  = VALUE_W + $clog2(MAX_ELEMENTS);
   localparam int UW  = TW + 1;
   localparam int MW  = TARGET_W + CW;

   state_type            state_ff, state_in;
   logic [TARGET_W-1:0]  target_ff, target_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [TW-1:0]        total_ff, total_in;
   logic [MW-1:0]        acc_ff, acc_in;
   logic [MW-1:0]        mcand_ff, mcand_in;
   logic [CW-1:0]        mplier_ff, mplier_in;
   logic [UW-1:0]        cur_ff, cur_in;
   logic [PW-1:0]        rpos_ff, rpos_in;
   logic [PW-1:0]        lpos_ff, lpos_in;
   logic [AW-1:0]        rmod_ff, rmod_in;
   logic [AW-1:0]        lmod_ff, lmod_in;
   logic [PW-1:0]        best_ff, best_in;
   logic [AW-1:0]        bst_ff, bst_in;
   logic                 inf_ff, inf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [START_W-1:0]   rsp_start_ff, rsp_start_in;
   logic [LEN_W-1:0]     rsp_len_ff, rsp_len_in;
   logic [VALUE_W-1:0]   rd_data_ff;

   logic [VALUE_W-1:0]   mem [MAX_ELEMENTS];
   logic                 mem_we;
   logic [AW-1:0]        rd_addr;

   logic                 div_start;
   logic                 div_done;
   logic [TARGET_W-1:0]  div_quo;
   logic [TW-1:0]        div_rem;

   logic [CW-1:0]        nm1;
   logic [PW-1:0]        last_pos;
   logic [PW-1:0]        wlen;
   logic [MW:0]          len_sum;
   logic [AW:0]          start_sum;

   // Pass count and remainder
   cmws_div #(
      .TOTAL_W (TW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (target_ff),
      .divisor   (total_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Element store: write on load, registered read for the window walk
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[AW-1:0]] <= req_tdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Derived window quantities
   always_comb begin
      nm1       = count_ff - CW'(1);
      last_pos  = {count_ff, 1'b0} - PW'(1);
      wlen      = rpos_ff - lpos_ff + PW'(1);
      len_sum   = {1'b0, acc_ff} + (MW + 1)'(best_ff);
      start_sum = (AW + 1)'(bst_ff) + (AW + 1)'(1);
   end

   // Sequencer next state and datapath
   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      cur_in       = cur_ff;
      rpos_in      = rpos_ff;
      lpos_in      = lpos_ff;
      rmod_in      = rmod_ff;
      lmod_in      = lmod_ff;
      best_in      = best_ff;
      bst_in       = bst_ff;
      inf_in       = inf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_start_in = rsp_start_ff;
      rsp_len_in   = rsp_len_ff;
      mem_we       = 1'b0;
      rd_addr      = rmod_ff;
      div_start    = 1'b0;

      // Take the register write
      if (csr_wr_en) begin
         target_in = csr_wr_data;
      end

      // Drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (count_ff < CW'(MAX_ELEMENTS)) begin
                  mem_we   = 1'b1;
                  total_in = total_ff + TW'(req_tdata);
                  count_in = count_ff + CW'(1);
               end
               if (req_tlast) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            inf_in = (total_ff == '0);
            if (total_ff == '0) begin
               state_in = S_FIN;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               mcand_in  = MW'(div_quo);
               mplier_in = count_ff;
               acc_in    = '0;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            if (mplier_ff == '0) begin
               if (div_rem == '0) begin
                  best_in  = '0;
                  bst_in   = '0;
                  state_in = S_FIN;
               end else begin
                  cur_in   = '0;
                  rpos_in  = '0;
                  lpos_in  = '0;
                  rmod_in  = '0;
                  lmod_in  = '0;
                  best_in  = '1;
                  bst_in   = '0;
                  state_in = S_RD_R;
               end
            end else begin
               if (mplier_ff[0]) begin
                  acc_in = acc_ff + mcand_ff;
               end
               mcand_in  = {mcand_ff[MW-2:0], 1'b0};
               mplier_in = mplier_ff >> 1;
            end
         end
         S_RD_R: begin
            rd_addr  = rmod_ff;
            state_in = S_ADD;
         end
         S_ADD: begin
            cur_in   = cur_ff + UW'(rd_data_ff);
            state_in = S_CHK;
         end
         S_CHK: begin
            if ((lpos_ff <= rpos_ff) && (cur_ff >= {1'b0, div_rem})) begin
               // Record a shorter window, then read its left element
               if (wlen < best_ff) begin
                  best_in = wlen;
                  bst_in  = lmod_ff;
               end
               rd_addr  = lmod_ff;
               state_in = S_SUB;
            end else if (rpos_ff == last_pos) begin
               state_in = S_FIN;
            end else begin
               rpos_in  = rpos_ff + PW'(1);
               rmod_in  = (rmod_ff == nm1[AW-1:0]) ? '0 : rmod_ff + AW'(1);
               state_in = S_RD_R;
            end
         end
         S_SUB: begin
            cur_in   = cur_ff - UW'(rd_data_ff);
            lpos_in  = lpos_ff + PW'(1);
            lmod_in  = (lmod_ff == nm1[AW-1:0]) ? '0 : lmod_ff + AW'(1);
            state_in = S_CHK;
         end
         S_FIN: begin
            // Load the response once the register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (inf_ff) begin
                  rsp_start_in = START_W'(1);
                  rsp_len_in   = '1;
               end else begin
                  rsp_start_in = START_W'(start_sum);
                  rsp_len_in   = (|len_sum[MW:LEN_W]) ? '1 : len_sum[LEN_W-1:0];
               end
               count_in = '0;
               total_in = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         target_ff    <= TARGET_W'(1);
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      cur_ff       <= cur_in;
      rpos_ff      <= rpos_in;
      lpos_ff      <= lpos_in;
      rmod_ff      <= rmod_in;
      lmod_ff      <= lmod_in;
      best_ff      <= best_in;
      bst_ff       <= bst_in;
      inf_ff       <= inf_in;
      rsp_start_ff <= rsp_start_in;
      rsp_len_ff   <= rsp_len_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - START_W - LEN_W){1'b0}}, rsp_len_ff, rsp_start_ff};

   // Element count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ELEMENTS))
      else $error("element count beyond store depth");

   // Left pointer never passes right pointer plus one during the walk
   a_window_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK || state_ff == S_SUB) |->
         ((PW + 1)'(lpos_ff) <= (PW + 1)'(rpos_ff) + (PW + 1)'(1)))
      else $error("window left pointer ahead of right pointer");

   // A finished walk always found a window no longer than the sequence
   a_best_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && !inf_ff) |-> (best_ff <= PW'(count_ff)))
      else $error("no qualifying window found");

   // Divider completes only while the sequencer waits on it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider done outside divide state");

endmodule

// ===== rtl/cmws_div.sv =====
// Restoring divider, one quotient bit per cycle, for the pass count and remainder.
// Depends on cmws_pkg for the dividend width and step counter width.
module cmws_div #(
   parameter int TOTAL_W = 42
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cmws_pkg::TARGET_W-1:0] dividend,
   input  logic [TOTAL_W-1:0]            divisor,
   output logic                          done,
   output logic [cmws_pkg::TARGET_W-1:0] quotient,
   output logic [TOTAL_W-1:0]            remainder
);
   import cmws_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic [TOTAL_W-1:0]    rem_ff;
   logic [TARGET_W-1:0]   quo_ff;

   logic [TOTAL_W:0]      trial;
   logic [TOTAL_W:0]      diff;
   logic                  fits;

   // Shift the next dividend bit into the partial remainder and try the subtract
   always_comb begin
      trial = {rem_ff, quo_ff[TARGET_W-1]};
      diff  = trial - {1'b0, divisor};
      fits  = (trial >= {1'b0, divisor});
   end

   // Advance one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
            quo_ff <= {quo_ff[TARGET_W-2:0], fits};
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(TARGET_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== verif/circular_min_window_sum_test.sv =====
// Self-checking test for circular_min_window_sum: loads element sequences, predicts the
// shortest circular run reaching target_sum and checks every response field by field.
// Depends on cmws_pkg and the circular_min_window_sum RTL.
`timescale 1ns / 1ps

module circular_min_window_sum_test;
   import cmws_pkg::*;

   localparam int          MAX_ELEMENTS = 1024;
   localparam int          HALF_PERIOD  = 10;
   localparam int          RESET_CYCLES = 4;
   localparam int          QUIET_CYCLES = 16;
   localparam int          SETTLE_CYCLES = 100;
   localparam int          HOLD_CYCLES  = 1500;
   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam logic [63:0] LEN_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [TARGET_W-1:0] TARGET_MAX = {TARGET_W{1'b1}};

   // How the values of one sequence are drawn
   typedef enum int {
      SCALE_FULL,
      SCALE_TINY,
      SCALE_EXTREME,
      SCALE_BYTE
   } value_scale_type;

   // How the threshold of a phase relates to the first sequence of that phase
   typedef enum int {
      TGT_WINDOW,
      TGT_MULTIPLE,
      TGT_SHORT,
      TGT_MAX,
      TGT_ONE,
      TGT_WIDE
   } target_mode_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } element_type;

   typedef struct packed {
      logic [START_W-1:0] start_index;
      logic [LEN_W-1:0]   run_length;
   } run_type;

   // Mirror of the block: element store, running total, threshold and expected runs
   class shortest_run_tracker_type;
      logic [VALUE_W-1:0] elements [MAX_ELEMENTS];
      logic [63:0]        target;
      logic [63:0]        total;
      int unsigned        count;
      run_type            pending_runs [$];
      int                 mismatch_count;

      function new();
         target = 64'd1;
         total = 64'd0;
         count = 0;
         mismatch_count = 0;
      endfunction

      function void set_target(logic [TARGET_W-1:0] t);
         target = 64'(t);
      endfunction

      // Shortest run over the doubled sequence reaching the remainder, plus whole passes
      function run_type shortest_run();
         logic [63:0] n, passes, rem, cur, lft, rgt, best, best_start;
         run_type r;
         r.start_index = START_W'(1);
         n = 64'(count);
         if (total == 0 || n == 0) begin
            r.run_length = LEN_MAX[LEN_W-1:0];
            return r;
         end
         passes = target / total;
         rem = target % total;
         if (rem == 0) begin
            r.run_length = (passes > LEN_MAX / n) ? LEN_MAX[LEN_W-1:0] : LEN_W'(passes * n);
            return r;
         end
         cur = 0;
         lft = 0;
         best = LEN_MAX;
         best_start = 0;
         for (rgt = 0; rgt < 2 * n; rgt++) begin
            cur += elements[int'(rgt % n)];
            while (lft <= rgt && cur >= rem) begin
               if (rgt - lft + 1 < best) begin
                  best = rgt - lft + 1;
                  best_start = lft;
               end
               cur -= elements[int'(lft % n)];
               lft++;
            end
         end
         r.start_index = START_W'((best_start % n) + 1);
         if (passes > (LEN_MAX - best) / n)
            r.run_length = LEN_MAX[LEN_W-1:0];
         else
            r.run_length = LEN_W'(passes * n + best);
         return r;
      endfunction

      // Store and sum while there is room; a last flag closes the sequence
      function void note_element(element_type e);
         if (count < MAX_ELEMENTS) begin
            elements[count] = e.value;
            total += 64'(e.value);
            count++;
         end
         if (e.last) begin
            pending_runs = {pending_runs, shortest_run()};
            total = 0;
            count = 0;
         end
      endfunction

      function void check_run(logic [RSP_DATA_W-1:0] data);
         run_type exp_run;
         logic [START_W-1:0] got_start;
         logic [LEN_W-1:0]   got_length;
         got_start = data[START_W-1:0];
         got_length = data[START_W +: LEN_W];
         if (pending_runs.size() == 0) begin
            $display("%0t: unexpected response: start_index %0d run_length %0d",
                     $time, got_start, got_length);
            mismatch_count++;
            return;
         end
         exp_run = pending_runs.pop_front();
         if (got_start !== exp_run.start_index) begin
            $display("%0t: start_index mismatch: expected %0d, actual %0d",
                     $time, exp_run.start_index, got_start);
            mismatch_count++;
         end
         if (got_length !== exp_run.run_length) begin
            $display("%0t: run_length mismatch: expected %0d, actual %0d",
                     $time, exp_run.run_length, got_length);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [VALUE_W-1:0]    req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en;
   logic [TARGET_W-1:0]   csr_wr_data;

   shortest_run_tracker_type runs = new();
   element_type         phase_elems [$];
   bit                  steady_flow = 1'b0;
   bit                  rsp_hold_request = 1'b0;
   int                  cycle_count = 0;

   circular_min_window_sum #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Check every accepted response against the oldest expected run
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         runs.check_run(rsp_tdata);
   end

   // Mostly short gaps, a few long ones, none while the flow is steady
   function automatic int pick_gap();
      int r;
      if (steady_flow)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 6);
      if (r < 95)
         return $urandom_range(7, 24);
      return $urandom_range(25, 64);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value(value_scale_type scale);
      logic [VALUE_W-1:0] v;
      case (scale)
         SCALE_FULL:    v = $urandom;
         SCALE_TINY:    v = $urandom_range(1, 16);
         SCALE_EXTREME: v = $urandom_range(0, 1) ? {VALUE_W{1'b1}} : VALUE_W'(1);
         default:       v = $urandom_range(1, 255);
      endcase
      if (v == 0)
         v = VALUE_W'(1);
      return v;
   endfunction

   // Threshold chosen against the first sequence's total and stored length
   function automatic logic [TARGET_W-1:0] pick_target(logic [63:0] seq_total, int n);
      logic [63:0]     wide;
      target_mode_type mode;
      int              r;
      wide = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 45)
         mode = TGT_WINDOW;
      else if (r < 60)
         mode = TGT_MULTIPLE;
      else if (r < 75)
         mode = TGT_SHORT;
      else if (r < 82)
         mode = TGT_MAX;
      else if (r < 88)
         mode = TGT_ONE;
      else
         mode = TGT_WIDE;
      case (mode)
         TGT_WINDOW:   wide = 1 + wide % (3 * seq_total);
         TGT_MULTIPLE: wide = seq_total * $urandom_range(1, 4);
         TGT_SHORT:    wide = 1 + wide % (seq_total / n);
         TGT_MAX:      wide = 64'(TARGET_MAX);
         TGT_ONE:      wide = 64'd1;
         default:      wide = {2'b00, wide[TARGET_W-1:0]};
      endcase
      if (wide[TARGET_W-1:0] == 0)
         wide = 64'd1;
      return wide[TARGET_W-1:0];
   endfunction

   function automatic void queue_element(logic [VALUE_W-1:0] v, logic lst);
      element_type e;
      e.value = v;
      e.last = lst;
      phase_elems = {phase_elems, e};
   endfunction

   function automatic logic [63:0] queue_sequence(int len, value_scale_type scale);
      logic [63:0]        seq_total;
      logic [VALUE_W-1:0] v;
      seq_total = 0;
      for (int i = 0; i < len; i++) begin
         v = pick_value(scale);
         queue_element(v, i == len - 1);
         if (i < MAX_ELEMENTS)
            seq_total += 64'(v);
      end
      return seq_total;
   endfunction

   // Offer one request after a random gap and note it once accepted
   task automatic send_element(element_type e);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= e.value;
      req_tlast <= e.last;
      do @(posedge clock); while (!req_tready);
      runs.note_element(e);
   endtask

   task automatic write_target(logic [TARGET_W-1:0] t);
      csr_wr_en <= 1'b1;
      csr_wr_data <= t;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      runs.set_target(t);
   endtask

   // Hold off until every expected run has come and the block has settled
   task automatic wait_idle();
      while (runs.pending_runs.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(logic [TARGET_W-1:0] t, bit hold);
      wait_idle();
      write_target(t);
      if (hold)
         rsp_hold_request = 1'b1;
      foreach (phase_elems[i])
         send_element(phase_elems[i]);
      req_tvalid <= 1'b0;
      phase_elems.delete();
   endtask

   // Response side: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold_request = 1'b0;
            stall_left = 0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      int          phase_idx;
      int          stored_items;
      int          nseq;
      int          len;
      int          first_len;
      bit          hold;
      logic [63:0] first_total;
      logic [63:0] seq_total;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Single elements at the value extremes, minimum threshold
      queue_element({VALUE_W{1'b1}}, 1'b1);
      queue_element(VALUE_W'(1), 1'b1);
      run_phase(TARGET_W'(1), 1'b0);

      // Maximum threshold: many whole passes plus a window
      queue_element({VALUE_W{1'b1}}, 1'b0);
      queue_element(VALUE_W'(1), 1'b0);
      queue_element(32'h8000_0000, 1'b1);
      run_phase(TARGET_MAX, 1'b0);

      // Remainder zero: two whole passes of a total of 10
      queue_element(VALUE_W'(3), 1'b0);
      queue_element(VALUE_W'(5), 1'b0);
      queue_element(VALUE_W'(2), 1'b1);
      run_phase(TARGET_W'(20), 1'b0);

      // Shortest run wraps from the end back to the start
      queue_element(VALUE_W'(5), 1'b0);
      queue_element(VALUE_W'(1), 1'b0);
      queue_element(VALUE_W'(1), 1'b0);
      queue_element(VALUE_W'(5), 1'b1);
      run_phase(TARGET_W'(11), 1'b0);

      // Ascending values, run sits inside the sequence without wrapping
      for (int i = 1; i <= 8; i++)
         queue_element(VALUE_W'(i), i == 8);
      run_phase(TARGET_W'(13), 1'b0);

      // Random phases: mostly short sequences, one past the store size
      phase_idx = 0;
      stored_items = 0;
      while (stored_items < 2000 || phase_idx < 40) begin
         hold = (phase_idx == 3 || phase_idx == 21);
         steady_flow = hold || ($urandom_range(0, 4) == 0);
         if (phase_idx == 12) begin
            // store full: the last three elements are dropped, last flag still counts
            first_total = queue_sequence(MAX_ELEMENTS + 3, SCALE_TINY);
            first_len = MAX_ELEMENTS;
            stored_items += MAX_ELEMENTS;
         end else begin
            nseq = hold ? 4 : $urandom_range(1, 5);
            for (int s = 0; s < nseq; s++) begin
               len = hold ? $urandom_range(1, 4) : pick_length();
               seq_total = queue_sequence(len, value_scale_type'($urandom_range(0, 3)));
               if (s == 0) begin
                  first_total = seq_total;
                  first_len = len;
               end
               stored_items += len;
            end
         end
         run_phase(pick_target(first_total, first_len), hold);
         phase_idx++;
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (runs.mismatch_count == 0 && runs.pending_runs.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
